// ===== design/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/md5_pkg.sv =====
package md5_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned CNT_W = 61;

  // controller -> datapath commands
  typedef struct packed {
    logic       put_byte;   // store in_byte at pos, clear rest of word on byte 0
    logic [7:0] in_byte;
    logic       count_inc;
    logic       zero_word;  // write zero to word index wz_idx
    logic [3:0] wz_idx;
    logic       put_len;    // write bit length into words 14 and 15
    logic       rnd_start;  // load a..d from chaining value
    logic       rnd_step;
    logic [5:0] rnd_idx;
    logic       cv_add;
    logic       cv_init;
    logic       cnt_clr;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] pos;        // byte position within block
  } md5_sts_t;

  function automatic logic [31:0] rconst(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return t[i];
  endfunction

  function automatic logic [4:0] rshift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ===== design/md5_hash_engine.sv =====
// MD5 engine, one byte per input transfer.
// Throughput: one byte per cycle; the byte that fills a block stalls intake
// while the 64 rounds run on one shared round unit, then the fold.
// Last transfer: pad, zero words and length, plus one or two compressions,
// then 4 digest transfers.
// Reset: async active low; chaining value to the MD5 IV, byte count to zero.
module md5_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_number_o,
  output logic        last_word_o
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;
  logic [127:0]      cv;

  // sequencer: byte intake, padding, round count, digest output
  md5_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .byte_present_i,
    .last_item_i, .out_valid_o, .out_stall_i, .word_number_o, .last_word_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  // block buffer, round unit, chaining value and byte counter
  md5_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cv_o(cv)
  );

  // digest word select; chaining value is stable while output waits
  assign digest_word_o = cv[32*word_number_o +: 32];

endmodule

// ===== design/md5_datapath.sv =====
module md5_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  md5_pkg::md5_cmd_t cmd_i,
  output md5_pkg::md5_sts_t sts_o,
  output logic [127:0]     cv_o
);

  logic [31:0] blk_q [16];
  logic [31:0] cv_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [md5_pkg::CNT_W-1:0] cnt_q;

  logic [31:0] f, sum, rot;
  logic [3:0]  g;
  logic [5:0]  i;
  logic [3:0]  wi;
  logic [1:0]  bi;
  logic [63:0] bits;

  assign i  = cmd_i.rnd_idx;
  assign wi = cnt_q[5:2];
  assign bi = cnt_q[1:0];
  assign bits = {cnt_q, 3'b000};

  always_comb begin
    case (i[5:4])
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = i[3:0]; end
      2'd1: begin f = (d_q & b_q) | (~d_q & c_q); g = 4'(5 * i + 1); end
      2'd2: begin f = b_q ^ c_q ^ d_q;            g = 4'(3 * i + 5); end
      default: begin f = c_q ^ (b_q | ~d_q);      g = 4'(7 * i); end
    endcase
    sum = a_q + f + md5_pkg::rconst(i) + blk_q[g];
    rot = 32'({sum, sum} >> (6'd32 - {1'b0, md5_pkg::rshift(i)}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_byte) begin
      if (bi == 2'd0) blk_q[wi] <= {24'd0, cmd_i.in_byte};
      else blk_q[wi][8*bi +: 8] <= cmd_i.in_byte;
    end
    if (cmd_i.zero_word) blk_q[cmd_i.wz_idx] <= '0;
    if (cmd_i.put_len) begin
      blk_q[14] <= bits[31:0];
      blk_q[15] <= bits[63:32];
    end
    if (cmd_i.rnd_start) begin
      a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
    end else if (cmd_i.rnd_step) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q  <= '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
      cnt_q <= '0;
    end else begin
      if (cmd_i.cv_init)
        cv_q <= '{md5_pkg::IV0, md5_pkg::IV1, md5_pkg::IV2, md5_pkg::IV3};
      else if (cmd_i.cv_add) begin
        cv_q[0] <= cv_q[0] + a_q; cv_q[1] <= cv_q[1] + b_q;
        cv_q[2] <= cv_q[2] + c_q; cv_q[3] <= cv_q[3] + d_q;
      end
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.count_inc) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.pos = cnt_q[5:0];
  assign cv_o = {cv_q[3], cv_q[2], cv_q[1], cv_q[0]};

endmodule

// ===== design/md5_ctrl.sv =====
module md5_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_present_i,
  input  logic              last_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        word_number_o,
  output logic              last_word_o,
  input  md5_pkg::md5_sts_t sts_i,
  output md5_pkg::md5_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;  // accept bytes
  localparam logic [2:0] S_PAD  = 3'd1;  // write pad byte
  localparam logic [2:0] S_ZERO = 3'd2;  // zero tail words
  localparam logic [2:0] S_LEN  = 3'd3;  // write length
  localparam logic [2:0] S_RND  = 3'd4;  // 64 rounds
  localparam logic [2:0] S_ADD  = 3'd5;  // fold into chaining value
  localparam logic [2:0] S_OUT  = 3'd6;  // emit digest

  logic [2:0] state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [3:0] wz_q, wz_d;
  logic       fin_q, fin_d;     // finalizing message
  logic       pad_q, pad_d;     // pad byte already written
  logic       two_q, two_d;     // length goes in a second block
  logic [1:0] wn_q, wn_d;
  logic       acc;

  assign in_stall_o    = (state_q != S_IDLE);
  assign acc           = in_valid_i && !in_stall_o;
  assign out_valid_o   = (state_q == S_OUT);
  assign word_number_o = wn_q;
  assign last_word_o   = (wn_q == 2'd3);

  always_comb begin
    state_d = state_q; rnd_d = rnd_q; wz_d = wz_q;
    fin_d = fin_q; pad_d = pad_q; two_d = two_q; wn_d = wn_q;
    cmd_o = '0;
    cmd_o.in_byte = data_byte_i;
    cmd_o.rnd_idx = rnd_q;
    cmd_o.wz_idx  = wz_q;
    case (state_q)
      S_IDLE: if (acc) begin
        if (byte_present_i) begin
          cmd_o.put_byte = 1'b1;
          cmd_o.count_inc = 1'b1;
        end
        fin_d = last_item_i;
        if (byte_present_i && sts_i.pos == 6'd63) begin
          cmd_o.rnd_start = 1'b1; rnd_d = '0; state_d = S_RND;
        end else if (last_item_i) state_d = S_PAD;
      end
      S_PAD: begin
        cmd_o.put_byte = 1'b1;
        cmd_o.in_byte = md5_pkg::PAD_BYTE;
        pad_d = 1'b1;
        two_d = (sts_i.pos >= 6'd56);
        wz_d  = sts_i.pos[5:2] + 4'd1;
        state_d = (sts_i.pos[5:2] == 4'd15) ? S_LEN : S_ZERO;
      end
      S_ZERO: begin
        cmd_o.zero_word = 1'b1;
        wz_d = wz_q + 4'd1;
        if (wz_q == 4'd15) state_d = S_LEN;
      end
      S_LEN: begin
        if (!two_q) cmd_o.put_len = 1'b1;
        cmd_o.rnd_start = 1'b1; rnd_d = '0; state_d = S_RND;
      end
      S_RND: begin
        cmd_o.rnd_step = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.cv_add = 1'b1;
        if (!fin_q) state_d = S_IDLE;
        else if (!pad_q) state_d = S_PAD;  // last byte filled the block
        else if (two_q) begin
          two_d = 1'b0; wz_d = '0; state_d = S_ZERO;
        end else begin
          wn_d = '0; state_d = S_OUT;
        end
      end
      S_OUT: if (!out_stall_i) begin
        wn_d = wn_q + 2'd1;
        if (wn_q == 2'd3) begin
          cmd_o.cv_init = 1'b1; cmd_o.cnt_clr = 1'b1;
          fin_d = 1'b0; pad_d = 1'b0; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rnd_q <= '0; wz_q <= '0;
      fin_q <= 1'b0; pad_q <= 1'b0; two_q <= 1'b0; wn_q <= '0;
    end else begin
      state_q <= state_d; rnd_q <= rnd_d; wz_q <= wz_d;
      fin_q <= fin_d; pad_q <= pad_d; two_q <= two_d; wn_q <= wn_d;
    end
  end

endmodule

// ===== design/md5_checker.sv =====
`include "assert_macros.svh"
module md5_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] word_number_o,
  input logic       last_word_o
);
  // no intake while digest is out
  `ASSERT_IMPL(a_no_in_on_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `ASSERT_IMPL(a_last_w3, clk_i, rst_ni, out_valid_o, last_word_o == (word_number_o == 2'd3))
  `ASSERT_NEXT(a_word_seq, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_word_o,
    out_valid_o && word_number_o == $past(word_number_o) + 2'd1)
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(word_number_o))
endmodule

bind md5_hash_engine md5_checker u_md5_checker (.*);

// ===== tb/sv/md5_digest_checker.sv =====
module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] digest_word_i,
  input  logic [1:0]  word_number_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  num;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];
  logic [31:0] cv [4];
  logic [31:0] blk [16];
  logic [60:0] byte_cnt;

  function automatic logic [31:0] round_k(int i);
    real v;
    // MD5 constant: floor(abs(sin(i+1)) * 2^32)
    v = $sin(i + 1);
    if (v < 0) v = -v;
    return 32'(longint'($floor(v * 4294967296.0)));
  endfunction

  function automatic logic [4:0] round_s(int i);
    int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return 5'(shifts[((i >> 4) << 2) | (i & 3)]);
  endfunction

  task automatic compress();
    logic [31:0] a, b, c, d, f, t, x;
    int g;
    a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
    for (int i = 0; i < 64; i++) begin
      case (i >> 4)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5 * i + 1) & 15; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) & 15; end
        default: begin f = c ^ (b | ~d); g = (7 * i) & 15; end
      endcase
      x = a + f + round_k(i) + blk[g];
      t = d; d = c; c = b;
      b = b + ((x << round_s(i)) | (x >> (6'd32 - round_s(i))));
      a = t;
    end
    cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d;
  endtask

  task automatic put(int pos, logic [7:0] v);
    blk[pos >> 2][(pos & 3) * 8 +: 8] = v;
  endtask

  task automatic init_cv();
    cv[0] = md5_pkg::IV0; cv[1] = md5_pkg::IV1;
    cv[2] = md5_pkg::IV2; cv[3] = md5_pkg::IV3;
    byte_cnt = '0;
  endtask

  task automatic absorb(logic [7:0] b, logic pres, logic fin);
    int pos;
    logic [63:0] bits;
    if (pres) begin
      put(int'(byte_cnt[5:0]), b);
      byte_cnt++;
      if (byte_cnt[5:0] == 0) compress();
    end
    if (fin) begin
      pos = int'(byte_cnt[5:0]);
      put(pos, md5_pkg::PAD_BYTE);
      for (int i = pos + 1; i < 64; i++) put(i, 8'h00);
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {byte_cnt, 3'b000};
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      compress();
      for (int i = 0; i < 4; i++) digest_q.push_back({cv[i], 2'(i), i == 3});
      init_cv();
      digests_o++;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    digests_o = 0;
    init_cv();
    for (int i = 0; i < 16; i++) blk[i] = '0;
  end

  assign pending_o = digest_q.size();

  always @(posedge clk_i) begin
    digest_word_t w;
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        report("unexpected word", digest_word_i, 32'h0);
      end else begin
        w = digest_q.pop_front();
        if (digest_word_i !== w.word) report("digest_word", digest_word_i, w.word);
        if (word_number_i !== w.num) report("word_number", word_number_i, w.num);
        if (last_word_i !== w.last) report("last_word", last_word_i, w.last);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_i)
      absorb(data_byte_i, byte_present_i, last_item_i);
  end
endmodule

// ===== tb/sv/md5_hash_engine_tb.sv =====
module md5_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_present_i = 1'b0;
  logic        last_item_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [31:0] digest_word_o;
  logic [1:0]  word_number_o;
  logic        last_word_o;
  int          fail_count, pending, digests;
  int          idle_cycles;
  int          items_sent;
  bit          hold_off_req = 1'b0;   // sender asks receiver for a long stall
  bit          stim_done = 1'b0;

  localparam int IdleLimit = 4000;

  always #1 clk_i = ~clk_i;

  md5_hash_engine dut (.*);

  md5_digest_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i,
    .byte_present_i, .last_item_i, .out_valid_i(out_valid_o), .out_stall_i,
    .digest_word_i(digest_word_o), .word_number_i(word_number_o),
    .last_word_i(last_word_o), .fail_count_o(fail_count), .pending_o(pending),
    .digests_o(digests)
  );

  // Random gap, then offer one transfer and hold it until accepted.
  // Returns at the accepting edge with valid still high.
  task automatic send(logic [7:0] b, logic pres, logic fin);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;  // bursts without idling
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    byte_present_i <= pres;
    last_item_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // One message of len random bytes; optionally closes with a data-carrying
  // last transfer, and sprinkles in empty transfers as noise.
  task automatic send_msg(int len, bit last_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send(8'($urandom), 1'b0, 1'b0);
      if (last_with_byte && i == len - 1) send(8'($urandom), 1'b1, 1'b1);
      else send(8'($urandom), 1'b1, 1'b0);
    end
    if (!last_with_byte || len == 0) send(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Receiver: random wait before each word, plus a long hold-off on request.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        wait_n = $urandom_range(0, 4);
        if (wait_n > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_n) @(negedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    idle_cycles = 0;
    items_sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: empty message, empty noise transfer, one-byte messages with extreme values.
    send(8'h00, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'hff, 1'b1, 1'b1);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    drain();
    // Full-length messages at padding boundaries (55 and 56 bytes)
    send_msg(55, 1'b1);
    send_msg(56, 1'b0);
    drain();
    // Long receiver hold-off while the sender keeps offering
    hold_off_req = 1'b1;
    send_msg(3, 1'b0);
    send_msg(2, 1'b1);
    send_msg(63, 1'b0);
    drain();
    send_msg(64, 1'b1);
    drain();
    // Random messages, mostly short, a few spanning blocks
    while (items_sent < 360) begin
      if ($urandom_range(0, 7) == 0) send_msg($urandom_range(50, 130), $urandom_range(0, 1));
      else send_msg($urandom_range(0, 12), $urandom_range(0, 1));
      if ($urandom_range(0, 5) == 0) drain();
    end
    drain();
    repeat (200) @(negedge clk_i);
    $display("Covered %0d input transfers and %0d digests, incl. empty and", items_sent,
             digests);
    $display("boundary-length messages, noise transfers and long output stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/md5_pkg.sv
design/md5_datapath.sv
design/md5_ctrl.sv
design/md5_hash_engine.sv
design/md5_checker.sv
tb/sv/md5_digest_checker.sv
tb/sv/md5_hash_engine_tb.sv
